// ===== sv/sit_pkg.sv =====
package sit_pkg;

  // Coordinate, difference, product and cross product widths
  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int CrossW = ProdW + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  // Coordinate differences for both straddle tests plus the box result
  typedef struct packed {
    logic  box_ok;
    diff_t dx;
    diff_t dy;
    diff_t u1x;
    diff_t u1y;
    diff_t u2x;
    diff_t u2y;
    diff_t ex;
    diff_t ey;
    diff_t v3x;
    diff_t v3y;
    diff_t v4x;
    diff_t v4y;
  } diff_set_t;

  // Product pairs; each cross product is first minus second
  typedef struct packed {
    logic  box_ok;
    prod_t c1a;
    prod_t c1b;
    prod_t c2a;
    prod_t c2b;
    prod_t c3a;
    prod_t c3b;
    prod_t c4a;
    prod_t c4b;
  } prod_set_t;

  // Sign-extend a coordinate to difference width
  function automatic diff_t sx(input coord_t v);
    sx = {v[CoordW-1], v};
  endfunction

  // True when the closed ranges [p0,p1] and [q0,q1] meet, in either order
  function automatic logic ranges_meet(input coord_t p0, input coord_t p1,
                                       input coord_t q0, input coord_t q1);
    coord_t plo;
    coord_t phi;
    coord_t qlo;
    coord_t qhi;
    plo = (p0 < p1) ? p0 : p1;
    phi = (p0 < p1) ? p1 : p0;
    qlo = (q0 < q1) ? q0 : q1;
    qhi = (q0 < q1) ? q1 : q0;
    ranges_meet = (phi >= qlo) && (qhi >= plo);
  endfunction

endpackage

// ===== sv/sit_diff.sv =====
module sit_diff (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  sit_pkg::coord_t    ax0,
  input  sit_pkg::coord_t    ay0,
  input  sit_pkg::coord_t    ax1,
  input  sit_pkg::coord_t    ay1,
  input  sit_pkg::coord_t    bx0,
  input  sit_pkg::coord_t    by0,
  input  sit_pkg::coord_t    bx1,
  input  sit_pkg::coord_t    by1,
  output logic               dn_valid,
  input  logic               dn_ready,
  output sit_pkg::diff_set_t dn_data
);

  logic               valid_r;
  sit_pkg::diff_set_t data_r;
  sit_pkg::diff_set_t data_nxt;

  // Form differences and the bounding box test
  always_comb begin
    data_nxt.box_ok = sit_pkg::ranges_meet(ax0, ax1, bx0, bx1) &&
                      sit_pkg::ranges_meet(ay0, ay1, by0, by1);
    data_nxt.dx  = sit_pkg::sx(ax1) - sit_pkg::sx(ax0);
    data_nxt.dy  = sit_pkg::sx(ay1) - sit_pkg::sx(ay0);
    data_nxt.u1x = sit_pkg::sx(bx1) - sit_pkg::sx(ax0);
    data_nxt.u1y = sit_pkg::sx(by1) - sit_pkg::sx(ay0);
    data_nxt.u2x = sit_pkg::sx(bx0) - sit_pkg::sx(ax0);
    data_nxt.u2y = sit_pkg::sx(by0) - sit_pkg::sx(ay0);
    data_nxt.ex  = sit_pkg::sx(bx0) - sit_pkg::sx(bx1);
    data_nxt.ey  = sit_pkg::sx(by0) - sit_pkg::sx(by1);
    data_nxt.v3x = sit_pkg::sx(ax1) - sit_pkg::sx(bx1);
    data_nxt.v3y = sit_pkg::sx(ay1) - sit_pkg::sx(by1);
    data_nxt.v4x = sit_pkg::sx(ax0) - sit_pkg::sx(bx1);
    data_nxt.v4y = sit_pkg::sx(ay0) - sit_pkg::sx(by1);
  end

  // Stage fills when empty or when its content moves on
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== sv/sit_mult.sv =====
module sit_mult (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  sit_pkg::diff_set_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output sit_pkg::prod_set_t dn_data
);

  logic               valid_r;
  sit_pkg::prod_set_t data_r;
  sit_pkg::prod_set_t data_nxt;
  sit_pkg::diff_t     dx, dy, u1x, u1y, u2x, u2y, ex, ey, v3x, v3y, v4x, v4y;

  // Unpack differences as signed values
  always_comb begin
    dx  = up_data.dx;
    dy  = up_data.dy;
    u1x = up_data.u1x;
    u1y = up_data.u1y;
    u2x = up_data.u2x;
    u2y = up_data.u2y;
    ex  = up_data.ex;
    ey  = up_data.ey;
    v3x = up_data.v3x;
    v3y = up_data.v3y;
    v4x = up_data.v4x;
    v4y = up_data.v4y;
  end

  // Eight exact 17x17 products
  always_comb begin
    data_nxt.box_ok = up_data.box_ok;
    data_nxt.c1a = sit_pkg::prod_t'(dx) * sit_pkg::prod_t'(u1y);
    data_nxt.c1b = sit_pkg::prod_t'(u1x) * sit_pkg::prod_t'(dy);
    data_nxt.c2a = sit_pkg::prod_t'(dx) * sit_pkg::prod_t'(u2y);
    data_nxt.c2b = sit_pkg::prod_t'(u2x) * sit_pkg::prod_t'(dy);
    data_nxt.c3a = sit_pkg::prod_t'(ex) * sit_pkg::prod_t'(v3y);
    data_nxt.c3b = sit_pkg::prod_t'(v3x) * sit_pkg::prod_t'(ey);
    data_nxt.c4a = sit_pkg::prod_t'(ex) * sit_pkg::prod_t'(v4y);
    data_nxt.c4b = sit_pkg::prod_t'(v4x) * sit_pkg::prod_t'(ey);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== sv/sit_decide.sv =====
module sit_decide (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  sit_pkg::prod_set_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic               dn_hit
);

  typedef logic signed [sit_pkg::CrossW-1:0] cross_t;

  logic   valid_r;
  logic   hit_r;
  logic   hit_nxt;
  cross_t c1, c2, c3, c4;

  // True when both values are nonzero with the same sign
  function automatic logic same_side(input cross_t p, input cross_t q);
    same_side = (p != '0) && (q != '0) && (p[sit_pkg::CrossW-1] == q[sit_pkg::CrossW-1]);
  endfunction

  // Finish the cross products and combine with the box result
  always_comb begin
    c1 = cross_t'(up_data.c1a) - cross_t'(up_data.c1b);
    c2 = cross_t'(up_data.c2a) - cross_t'(up_data.c2b);
    c3 = cross_t'(up_data.c3a) - cross_t'(up_data.c3b);
    c4 = cross_t'(up_data.c4a) - cross_t'(up_data.c4b);
    hit_nxt = up_data.box_ok && !same_side(c1, c2) && !same_side(c3, c4);
  end

  // Output register: hold the result until the receiver takes it
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hit_r <= hit_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_hit   = hit_r;

endmodule

// ===== sv/segment_intersection_test.sv =====
// Segment intersection test for two closed 2D segments with signed 16-bit
// endpoints. Input channel: in_valid/in_ready with the eight endpoint
// coordinates; one transfer carries one segment pair. Result channel:
// out_valid/out_ready with out_hit, 1 when the segments meet or touch.
// Every input transfer yields exactly one result, in order.
// Pipeline stages, in order: difference and box stage, multiplier stage,
// cross product and decision stage. Throughput: one pair per cycle while
// the receiver does not stall.
// Each stage takes new data when it is empty or when its content moves on,
// so bubbles close up. When the receiver stalls, the output register holds
// its result and the stalled stages hold theirs; in_ready drops once the
// pipeline is full and nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties all stages; in_ready is high in
// the first cycle after reset.
module segment_intersection_test (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     in_a_start_x,
  input  logic signed [15:0]     in_a_start_y,
  input  logic signed [15:0]     in_a_end_x,
  input  logic signed [15:0]     in_a_end_y,
  input  logic signed [15:0]     in_b_start_x,
  input  logic signed [15:0]     in_b_start_y,
  input  logic signed [15:0]     in_b_end_x,
  input  logic signed [15:0]     in_b_end_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_hit
);

  logic               s1_valid;
  logic               s1_ready;
  sit_pkg::diff_set_t s1_data;
  logic               s2_valid;
  logic               s2_ready;
  sit_pkg::prod_set_t s2_data;

  // Differences and bounding box
  sit_diff u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .ax0      (in_a_start_x),
    .ay0      (in_a_start_y),
    .ax1      (in_a_end_x),
    .ay1      (in_a_end_y),
    .bx0      (in_b_start_x),
    .by0      (in_b_start_y),
    .bx1      (in_b_end_x),
    .by1      (in_b_end_y),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // Products
  sit_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  // Cross products, sign tests and output register
  sit_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_hit   (out_hit)
  );

endmodule

// ===== dv/segment_intersection_checker.sv =====
`timescale 1ns / 100ps
module segment_intersection_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  sit_pkg::coord_t in_a_start_x,
  input  sit_pkg::coord_t in_a_start_y,
  input  sit_pkg::coord_t in_a_end_x,
  input  sit_pkg::coord_t in_a_end_y,
  input  sit_pkg::coord_t in_b_start_x,
  input  sit_pkg::coord_t in_b_start_y,
  input  sit_pkg::coord_t in_b_end_x,
  input  sit_pkg::coord_t in_b_end_y,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic            out_hit,
  output int unsigned     mismatch_count,
  output int unsigned     pending_count
);

  // Expected hit flags, oldest first
  logic expected_hits [$];

  // Closed intervals in either endpoint order share at least one point
  function automatic logic spans_meet(input longint p0, input longint p1,
                                      input longint q0, input longint q1);
    longint plo;
    longint phi;
    longint qlo;
    longint qhi;
    plo = (p0 < p1) ? p0 : p1;
    phi = (p0 < p1) ? p1 : p0;
    qlo = (q0 < q1) ? q0 : q1;
    qhi = (q0 < q1) ? q1 : q0;
    return (phi >= qlo) && (qhi >= plo);
  endfunction

  // Both endpoints strictly on one side of the line
  function automatic logic strictly_one_side(input longint p, input longint q);
    return (p > 0 && q > 0) || (p < 0 && q < 0);
  endfunction

  // Exact integer intersection decision for one segment pair
  function automatic logic predict_hit(input sit_pkg::coord_t a0x,
                                       input sit_pkg::coord_t a0y,
                                       input sit_pkg::coord_t a1x,
                                       input sit_pkg::coord_t a1y,
                                       input sit_pkg::coord_t b0x,
                                       input sit_pkg::coord_t b0y,
                                       input sit_pkg::coord_t b1x,
                                       input sit_pkg::coord_t b1y);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint dx, dy, ex, ey;
    longint c1, c2, c3, c4;
    ax0 = a0x; ay0 = a0y; ax1 = a1x; ay1 = a1y;
    bx0 = b0x; by0 = b0y; bx1 = b1x; by1 = b1y;
    if (!spans_meet(ax0, ax1, bx0, bx1) || !spans_meet(ay0, ay1, by0, by1))
      return 1'b0;
    // b against the line through a
    dx = ax1 - ax0;
    dy = ay1 - ay0;
    c1 = dx * (by1 - ay0) - (bx1 - ax0) * dy;
    c2 = dx * (by0 - ay0) - (bx0 - ax0) * dy;
    if (strictly_one_side(c1, c2))
      return 1'b0;
    // a against the line through b
    ex = bx0 - bx1;
    ey = by0 - by1;
    c3 = ex * (ay1 - by1) - (ax1 - bx1) * ey;
    c4 = ex * (ay0 - by1) - (ax0 - bx1) * ey;
    return !strictly_one_side(c3, c4);
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // Predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    logic want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_hits.push_back(predict_hit(in_a_start_x, in_a_start_y,
                                            in_a_end_x, in_a_end_y,
                                            in_b_start_x, in_b_start_y,
                                            in_b_end_x, in_b_end_y));
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $error("out_hit: expected no result, actual %0b", out_hit);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_hits.pop_front();
          if (out_hit !== want) begin
            $error("out_hit: expected %0b, actual %0b", want, out_hit);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      pending_count <= expected_hits.size();
    end
  end

endmodule

// ===== dv/tb_segment_intersection_test.sv =====
`timescale 1ns / 100ps
module tb_segment_intersection_test;

  localparam int RandomPairs   = 1330;
  localparam int CalmTail      = 200;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;
  localparam int CoordMax      = 32767;
  localparam int CoordMin      = -32768;

  typedef struct packed {
    sit_pkg::coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  sit_pkg::coord_t in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y;
  sit_pkg::coord_t in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y;
  logic            out_valid;
  logic            out_ready;
  logic            out_hit;
  int unsigned     mismatch_count;
  int unsigned     pending_count;
  logic            bursts_on;
  int unsigned     quiet_cycles;

  segment_intersection_test dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_start_x (in_a_start_x),
    .in_a_start_y (in_a_start_y),
    .in_a_end_x   (in_a_end_x),
    .in_a_end_y   (in_a_end_y),
    .in_b_start_x (in_b_start_x),
    .in_b_start_y (in_b_start_y),
    .in_b_end_x   (in_b_end_x),
    .in_b_end_y   (in_b_end_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit)
  );

  segment_intersection_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_a_start_x   (in_a_start_x),
    .in_a_start_y   (in_a_start_y),
    .in_a_end_x     (in_a_end_x),
    .in_a_end_y     (in_a_end_y),
    .in_b_start_x   (in_b_start_x),
    .in_b_start_y   (in_b_start_y),
    .in_b_end_x     (in_b_end_x),
    .in_b_end_y     (in_b_end_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Saturate to the coordinate range
  function automatic sit_pkg::coord_t clip(input int v);
    if (v > CoordMax) return sit_pkg::coord_t'(CoordMax);
    if (v < CoordMin) return sit_pkg::coord_t'(CoordMin);
    return sit_pkg::coord_t'(v);
  endfunction

  function automatic seg_pair_t make_pair(input int ax0, input int ay0,
                                          input int ax1, input int ay1,
                                          input int bx0, input int by0,
                                          input int bx1, input int by1);
    seg_pair_t p;
    p.ax0 = clip(ax0); p.ay0 = clip(ay0); p.ax1 = clip(ax1); p.ay1 = clip(ay1);
    p.bx0 = clip(bx0); p.by0 = clip(by0); p.bx1 = clip(bx1); p.by1 = clip(by1);
    return p;
  endfunction

  function automatic int any_coord();
    return int'(sit_pkg::coord_t'($urandom));
  endfunction

  function automatic int offset(input int base, input int spread);
    return base + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // Random pair, biased toward touching, collinear and degenerate geometry
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int kind, base_x, base_y, spread, dx, dy;
    kind   = $urandom_range(0, 9);
    base_x = any_coord();
    base_y = any_coord();
    spread = $urandom_range(0, 1) ? 8 : 3000;
    p = make_pair(offset(base_x, spread), offset(base_y, spread),
                  offset(base_x, spread), offset(base_y, spread),
                  offset(base_x, spread), offset(base_y, spread),
                  offset(base_x, spread), offset(base_y, spread));
    case (kind)
      0, 1: begin
        p = make_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord(), any_coord());
      end
      5, 6: begin
        // shared endpoint
        p.bx0 = p.ax1;
        p.by0 = p.ay1;
      end
      7, 8: begin
        // points on one line through the base
        dx = int'($urandom_range(0, 8)) - 4;
        dy = int'($urandom_range(0, 8)) - 4;
        p = make_pair(base_x + (int'($urandom_range(0, 8)) - 4) * dx,
                      base_y + (int'($urandom_range(0, 8)) - 4) * dy,
                      base_x + (int'($urandom_range(0, 8)) - 4) * dx,
                      base_y + (int'($urandom_range(0, 8)) - 4) * dy,
                      base_x + (int'($urandom_range(0, 8)) - 4) * dx,
                      base_y + (int'($urandom_range(0, 8)) - 4) * dy,
                      base_x + (int'($urandom_range(0, 8)) - 4) * dx,
                      base_y + (int'($urandom_range(0, 8)) - 4) * dy);
        // keep the second segment on the same line as the first
        p.ax0 = clip(base_x); p.ay0 = clip(base_y);
        p.ax1 = clip(base_x + 3 * dx); p.ay1 = clip(base_y + 3 * dy);
        p.bx0 = clip(base_x + (int'($urandom_range(0, 10)) - 4) * dx);
        p.by0 = clip(base_y + (int'(p.bx0) - base_x) / ((dx == 0) ? 1 : dx) * dy);
        p.bx1 = clip(base_x + (int'($urandom_range(0, 10)) - 4) * dx);
        p.by1 = clip(base_y + (int'(p.bx1) - base_x) / ((dx == 0) ? 1 : dx) * dy);
        if (dx == 0) begin
          p.by0 = clip(base_y + (int'($urandom_range(0, 10)) - 4) * dy);
          p.by1 = clip(base_y + (int'($urandom_range(0, 10)) - 4) * dy);
        end
      end
      9: begin
        // degenerate segment
        if ($urandom_range(0, 1)) begin
          p.ax1 = p.ax0;
          p.ay1 = p.ay0;
        end else begin
          p.bx1 = p.bx0;
          p.by1 = p.by0;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  // Present one pair at the falling edge and hold it until transfer
  task automatic send_pair(input seg_pair_t p);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_a_start_x <= p.ax0;
    in_a_start_y <= p.ay0;
    in_a_end_x   <= p.ax1;
    in_a_end_y   <= p.ay1;
    in_b_start_x <= p.bx0;
    in_b_start_y <= p.by0;
    in_b_end_x   <= p.bx1;
    in_b_end_y   <= p.by1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver stalls in random bursts while enabled
  always begin
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[segment_intersection_test] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    out_ready    = 1'b0;
    bursts_on    = 1'b1;
    quiet_cycles = 0;
    in_a_start_x = '0; in_a_start_y = '0; in_a_end_x = '0; in_a_end_y = '0;
    in_b_start_x = '0; in_b_start_y = '0; in_b_end_x = '0; in_b_end_y = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // both segments collapsed onto one extreme point
    send_pair(make_pair(CoordMin, CoordMin, CoordMin, CoordMin,
                        CoordMin, CoordMin, CoordMin, CoordMin));
    send_pair(make_pair(CoordMax, CoordMax, CoordMax, CoordMax,
                        CoordMax, CoordMax, CoordMax, CoordMax));
    // full-range diagonals crossing, both endpoint orders
    send_pair(make_pair(CoordMin, CoordMin, CoordMax, CoordMax,
                        CoordMin, CoordMax, CoordMax, CoordMin));
    send_pair(make_pair(CoordMax, CoordMax, CoordMin, CoordMin,
                        CoordMax, CoordMin, CoordMin, CoordMax));
    // full-range axes crossing at the origin
    send_pair(make_pair(CoordMin, 0, CoordMax, 0, 0, CoordMin, 0, CoordMax));
    // point just off a near-diagonal full-range segment
    send_pair(make_pair(CoordMin, CoordMin, CoordMax, CoordMax - 1,
                        CoordMax - 1, CoordMax - 1, CoordMax - 1, CoordMax - 1));
    // parallel, boxes apart
    send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
    // boxes overlap, no crossing
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 4, 6));
    // shared endpoint
    send_pair(make_pair(0, 0, 5, 5, 5, 5, 10, 0));
    // endpoint touching the interior
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
    // collinear overlap, collinear touch, collinear apart
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(make_pair(0, 0, 5, 0, 5, 0, 9, 0));
    send_pair(make_pair(0, 0, 4, 0, 5, 0, 9, 0));
    send_pair(make_pair(-6, -3, 2, 1, 6, 3, 14, 7));
    // degenerate segment on, and off, the other one
    send_pair(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
    send_pair(make_pair(1, 4, 1, 4, 0, 0, 6, 6));
    send_pair(make_pair(0, 0, 6, 6, -2, -2, -2, -2));
    // two distinct points
    send_pair(make_pair(1, 1, 1, 1, 2, 2, 2, 2));
    // boxes touch at a corner only
    send_pair(make_pair(0, 5, 5, 0, 5, 5, 10, 10));

    // random pairs; quiet stretches every third block and at the end
    for (int n = 0; n < RandomPairs; n++) begin
      bursts_on = (n < RandomPairs - CalmTail) && ((n / 100) % 3 != 2);
      send_pair(random_pair());
    end
    in_valid <= 1'b0;

    wait (pending_count == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0)
      $display("[segment_intersection_test] OK");
    else
      $display("[segment_intersection_test] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sit_pkg.sv
sv/sit_diff.sv
sv/sit_mult.sv
sv/sit_decide.sv
sv/segment_intersection_test.sv
dv/segment_intersection_checker.sv
dv/tb_segment_intersection_test.sv
